/* src/gdoc_pkg.sv */
// ----------------------------------------------------------------------------
// gdoc_pkg: shared types and constants of the grid disc occupancy check
// Holds register indexes, item opcodes, the obstacle level and the divider
// widths and status type.
// ----------------------------------------------------------------------------
package gdoc_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_GRID_WIDTH   = 3'd0,
        REG_GRID_HEIGHT  = 3'd1,
        REG_ORIGIN_X     = 3'd2,
        REG_ORIGIN_Y     = 3'd3,
        REG_ORIGIN_COS   = 3'd4,
        REG_ORIGIN_SIN   = 3'd5,
        REG_CELL_SIZE    = 3'd6,
        REG_CLEAR_RADIUS = 3'd7
    } cfg_reg_t;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // A cell at or above this level is an obstacle.
    localparam logic signed [7:0] OBSTACLE_LEVEL = 8'sd99;

    // Iterative divider: dividend and divisor widths.
    localparam int DIV_NW = 35;
    localparam int DIV_DW = 31;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* src/gdoc_divider.sv */
// ----------------------------------------------------------------------------
// gdoc_divider: shared restoring divider
// Unsigned division, one quotient bit per cycle, a done pulse at the end.
// ----------------------------------------------------------------------------
module gdoc_divider
    import gdoc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_NW-1:0] dividend,
    input  logic [DIV_DW-1:0] divisor,
    output logic [DIV_NW-1:0] quotient,
    output div_stat_t         stat
);

    localparam int CW = $clog2(DIV_NW + 1);

    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] rem_next;
    logic [DIV_NW-1:0] quot_reg;
    logic [DIV_DW-1:0] dvs_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_DW:0]   shifted;
    logic              fits;

    always_comb
    begin
        shifted  = {rem_reg, quot_reg[DIV_NW-1]};
        fits     = shifted >= {1'b0, dvs_reg};
        rem_next = fits ? DIV_DW'(shifted - {1'b0, dvs_reg}) : shifted[DIV_DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DIV_NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quot_reg <= dividend;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[DIV_NW-2:0], fits};
        end
    end

    assign quotient  = quot_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* src/gdoc_cell_mem.sv */
// ----------------------------------------------------------------------------
// gdoc_cell_mem: occupancy cell memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gdoc_cell_mem
#(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/grid_disc_occupancy_check.sv */
// ----------------------------------------------------------------------------
// grid_disc_occupancy_check: disc collision check on an occupancy grid
// Keeps a grid of signed 8-bit cells and tests query points for obstacles
// within a clearance radius.
// ----------------------------------------------------------------------------
// Usage. Input beats carry an opcode. A write beat stores cell_value at
// cell_index in the cell memory in the cycle it is accepted and gives no
// result. A query beat gives exactly one output beat with occupied and in_map.
// Configuration is written through cfg_valid/cfg_ready, which is always ready;
// write it only while no query is in flight.
// Flow. A query runs its arithmetic through one shared bit-serial divider
// in three passes (x cell, y cell and the radius in cells), then scans the
// (2r+1)^2 cells around the point, where r is the clamped radius in cells;
// the scan visits one cell per cycle and reads those inside the map.
// A point outside the map skips the radius division and the scan. With a zero
// clearance radius the scan covers the one cell. One query is handled at a
// time.
// Reset clears the control state and the registers to their defaults; the
// cell memory is not cleared and must be written before it is read.
// A stalled result waits in the output register; the next input beat is
// still taken, and a further query finishes only once that slot is free.
// ----------------------------------------------------------------------------
module grid_disc_occupancy_check
    import gdoc_pkg::*;
#(
    parameter int MAP_SIDE         = 256,
    parameter int MAX_RADIUS_CELLS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [15:0] cell_index,
    input  logic [7:0]  cell_value,
    input  logic [31:0] point_x,
    input  logic [31:0] point_y,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        occupied,
    output logic        in_map,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int DEPTH = MAP_SIDE * MAP_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(MAX_RADIUS_CELLS + 1);
    localparam int OW    = RW + 1;
    localparam int PW    = OW + 10;
    localparam int MW    = 2 * OW + 1;
    localparam int TW    = MW + 63;

    localparam logic signed [OW-1:0] ONE_O = OW'(1);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_PROD  = 12'b000000000010,
        S_SUM   = 12'b000000000100,
        S_XGO   = 12'b000000001000,
        S_XWAIT = 12'b000000010000,
        S_YGO   = 12'b000000100000,
        S_YWAIT = 12'b000001000000,
        S_RGO   = 12'b000010000000,
        S_RWAIT = 12'b000100000000,
        S_SCAN  = 12'b001000000000,
        S_DRAIN = 12'b010000000000,
        S_DONE  = 12'b100000000000
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [8:0]         grid_width_reg;
    logic [8:0]         grid_height_reg;
    logic signed [31:0] origin_x_reg;
    logic signed [31:0] origin_y_reg;
    logic signed [15:0] origin_cos_reg;
    logic signed [15:0] origin_sin_reg;
    logic [30:0]        cell_size_reg;
    logic [30:0]        clear_radius_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg   <= 9'd256;
            grid_height_reg  <= 9'd256;
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            origin_cos_reg   <= 16'sd16384;
            origin_sin_reg   <= '0;
            cell_size_reg    <= 31'd6554;
            clear_radius_reg <= 31'd6554;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GRID_WIDTH:   grid_width_reg   <= cfg_data[8:0];
                REG_GRID_HEIGHT:  grid_height_reg  <= cfg_data[8:0];
                REG_ORIGIN_X:     origin_x_reg     <= cfg_data;
                REG_ORIGIN_Y:     origin_y_reg     <= cfg_data;
                REG_ORIGIN_COS:   origin_cos_reg   <= cfg_data[15:0];
                REG_ORIGIN_SIN:   origin_sin_reg   <= cfg_data[15:0];
                REG_CELL_SIZE:    cell_size_reg    <= cfg_data[30:0];
                REG_CLEAR_RADIUS: clear_radius_reg <= cfg_data[30:0];
                default:          ;
            endcase
        end
    end

    // Effective dimensions and cell size. Oversized grids act as the full
    // map side, and a zero cell size acts as one.
    logic [8:0]  grid_w;
    logic [8:0]  grid_h;
    logic [30:0] cs_eff;

    always_comb
    begin
        grid_w = (32'(grid_width_reg) > MAP_SIDE) ? 9'(MAP_SIDE) : grid_width_reg;
        grid_h = (32'(grid_height_reg) > MAP_SIDE) ? 9'(MAP_SIDE) : grid_height_reg;
        cs_eff = (cell_size_reg == '0) ? 31'd1 : cell_size_reg;
    end

    // Input handshake: an item is taken only in the idle state.
    logic accept;
    logic mem_wr_en;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign mem_wr_en = accept && (opcode == OP_WRITE) && (32'(cell_index) < 32'(DEPTH));

    // Query point captured on acceptance.
    logic signed [31:0] px_reg;
    logic signed [31:0] py_reg;

    always_ff @(posedge clk)
    begin
        if (accept && (opcode == OP_QUERY))
        begin
            px_reg <= point_x;
            py_reg <= point_y;
        end
    end

    // Offset from the origin, then the rotation products, then their sums.
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [48:0] p_cx_reg;
    logic signed [48:0] p_sy_reg;
    logic signed [48:0] p_cy_reg;
    logic signed [48:0] p_sx_reg;
    logic signed [49:0] gx_reg;
    logic signed [49:0] gy_reg;
    logic [61:0]        cs2_reg;
    logic [61:0]        cr2_reg;

    always_comb
    begin
        dx = 33'(px_reg) - 33'(origin_x_reg);
        dy = 33'(py_reg) - 33'(origin_y_reg);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_PROD)
        begin
            p_cx_reg <= origin_cos_reg * dx;
            p_sy_reg <= origin_sin_reg * dy;
            p_cy_reg <= origin_cos_reg * dy;
            p_sx_reg <= origin_sin_reg * dx;
            cs2_reg  <= cs_eff * cs_eff;
            cr2_reg  <= clear_radius_reg * clear_radius_reg;
        end
        if (state_reg == S_SUM)
        begin
            gx_reg <= 50'(p_cx_reg) + 50'(p_sy_reg);
            gy_reg <= 50'(p_cy_reg) - 50'(p_sx_reg);
        end
    end

    // Shared divider. The Q.14 coordinate is floored by 2^14 first, then by
    // the cell size; a negative value is divided as its complement.
    logic [DIV_NW-1:0] div_dividend;
    logic [DIV_NW-1:0] div_quot;
    logic              div_start;
    div_stat_t         div_stat;

    always_comb
    begin
        case (state_reg)
            S_XGO:   div_dividend = gx_reg[49] ? ~gx_reg[48:14] : gx_reg[48:14];
            S_YGO:   div_dividend = gy_reg[49] ? ~gy_reg[48:14] : gy_reg[48:14];
            default: div_dividend = DIV_NW'(32'(clear_radius_reg) + 32'(cs_eff) - 32'd1);
        endcase
    end

    assign div_start = (state_reg == S_XGO) || (state_reg == S_YGO) || (state_reg == S_RGO);

    gdoc_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cs_eff),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    // Cell coordinates of the query point and the scan state.
    logic              x_in_reg;
    logic [8:0]        cx_reg;
    logic [8:0]        cy_reg;
    logic [RW-1:0]     ri_reg;
    logic signed [OW-1:0] ox_reg;
    logic signed [OW-1:0] oy_reg;
    logic              occ_reg;
    logic              map_reg;
    logic              y_in;
    logic [RW-1:0]     ri_clamped;
    logic signed [OW-1:0] ri_pos;
    logic signed [OW-1:0] ri_neg;

    always_comb
    begin
        y_in = !gy_reg[49] && (div_quot < DIV_NW'(grid_h));
        if (div_quot > DIV_NW'(MAX_RADIUS_CELLS))
        begin
            ri_clamped = RW'(MAX_RADIUS_CELLS);
        end
        else if (div_quot == '0)
        begin
            ri_clamped = RW'(1);
        end
        else
        begin
            ri_clamped = div_quot[RW-1:0];
        end
        ri_pos = $signed({1'b0, ri_reg});
        ri_neg = -ri_pos;
    end

    // Scan stage 0: cell position, bounds, memory address and squared offset m.
    logic signed [PW-1:0]   mx;
    logic signed [PW-1:0]   my;
    logic                   s0_in;
    logic [18:0]            s0_lin;
    logic [AW-1:0]          rd_addr;
    logic signed [2*OW-1:0] sq_x;
    logic signed [2*OW-1:0] sq_y;
    logic [MW-1:0]          s0_m;
    logic                   scan_rd;

    always_comb
    begin
        mx      = PW'($signed({1'b0, cx_reg})) + PW'(ox_reg);
        my      = PW'($signed({1'b0, cy_reg})) + PW'(oy_reg);
        s0_in   = !mx[PW-1] && !my[PW-1]
                  && ($unsigned(mx) < PW'(grid_w)) && ($unsigned(my) < PW'(grid_h));
        s0_lin  = 19'(my[8:0] * grid_w) + 19'(mx[8:0]);
        rd_addr = AW'(s0_lin);
        sq_x    = ox_reg * ox_reg;
        sq_y    = oy_reg * oy_reg;
        s0_m    = MW'($unsigned(sq_x)) + MW'($unsigned(sq_y));
        scan_rd = (state_reg == S_SCAN) && s0_in;
    end

    logic [7:0] mem_rd_data;

    gdoc_cell_mem
    #(
        .DEPTH (DEPTH),
        .AW    (AW)
    )
    u_mem
    (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (AW'(cell_index)),
        .wr_data (cell_value),
        .rd_en   (scan_rd),
        .rd_addr (rd_addr),
        .rd_data (mem_rd_data)
    );

    // Scan stage 1: obstacle test on read data, distance products.
    // Scan stage 2: disc test, m * cs^2 <= radius^2, and accumulation.
    logic              s1_valid_reg;
    logic [MW-1:0]     s1_m_reg;
    logic              s2_valid_reg;
    logic [MW+31:0]    s2_plo_reg;
    logic [MW+29:0]    s2_phi_reg;
    logic              s1_obst;
    logic [TW-1:0]     s2_total;
    logic              s2_hit;

    always_comb
    begin
        s1_obst  = $signed(mem_rd_data) >= OBSTACLE_LEVEL;
        s2_total = (TW'(s2_phi_reg) << 32) + TW'(s2_plo_reg);
        s2_hit   = s2_valid_reg && (s2_total <= TW'(cr2_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= scan_rd;
            s2_valid_reg <= s1_valid_reg && s1_obst;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_m_reg   <= s0_m;
        s2_plo_reg <= s1_m_reg * cs2_reg[31:0];
        s2_phi_reg <= s1_m_reg * cs2_reg[61:32];
    end

    // Output register.
    logic out_valid_reg;
    logic occupied_reg;
    logic in_map_reg;
    logic out_load;

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            occupied_reg <= occ_reg;
            in_map_reg   <= map_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign occupied  = occupied_reg;
    assign in_map    = in_map_reg;

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            x_in_reg  <= 1'b0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            ri_reg    <= '0;
            ox_reg    <= '0;
            oy_reg    <= '0;
            occ_reg   <= 1'b0;
            map_reg   <= 1'b0;
        end
        else
        begin
            if (s2_hit)
            begin
                occ_reg <= 1'b1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && (opcode == OP_QUERY))
                    begin
                        state_reg <= S_PROD;
                    end
                end
                S_PROD:  state_reg <= S_SUM;
                S_SUM:   state_reg <= S_XGO;
                S_XGO:   state_reg <= S_XWAIT;
                S_XWAIT:
                begin
                    if (div_stat.done)
                    begin
                        x_in_reg  <= !gx_reg[49] && (div_quot < DIV_NW'(grid_w));
                        cx_reg    <= div_quot[8:0];
                        state_reg <= S_YGO;
                    end
                end
                S_YGO:   state_reg <= S_YWAIT;
                S_YWAIT:
                begin
                    if (div_stat.done)
                    begin
                        cy_reg  <= div_quot[8:0];
                        occ_reg <= 1'b0;
                        map_reg <= x_in_reg && y_in;
                        ri_reg  <= '0;
                        ox_reg  <= '0;
                        oy_reg  <= '0;
                        if (!(x_in_reg && y_in))
                        begin
                            state_reg <= S_DONE;
                        end
                        else if (clear_radius_reg == '0)
                        begin
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            state_reg <= S_RGO;
                        end
                    end
                end
                S_RGO:   state_reg <= S_RWAIT;
                S_RWAIT:
                begin
                    if (div_stat.done)
                    begin
                        ri_reg    <= ri_clamped;
                        ox_reg    <= -$signed({1'b0, ri_clamped});
                        oy_reg    <= -$signed({1'b0, ri_clamped});
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (ox_reg == ri_pos)
                    begin
                        ox_reg <= ri_neg;
                        if (oy_reg == ri_pos)
                        begin
                            state_reg <= S_DRAIN;
                        end
                        else
                        begin
                            oy_reg <= oy_reg + ONE_O;
                        end
                    end
                    else
                    begin
                        ox_reg <= ox_reg + ONE_O;
                    end
                end
                S_DRAIN:
                begin
                    if (!s1_valid_reg && !s2_valid_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Checks on the internal sequencing.
    a_occ_needs_map: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!occupied || in_map))
        else $error("occupied reported for a point outside the map");

    a_div_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> (state_reg == S_IDLE))
        else $error("cell write outside the idle state");

    a_scan_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (state_reg == S_SCAN || state_reg == S_DRAIN))
        else $error("scan pipeline active outside the scan");

endmodule

/* test/grid_disc_occupancy_check_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_disc_occupancy_check_checker: result checker for the grid disc check
// Watches the configuration, input and output channels, keeps its own copy
// of the registers and the cell memory, predicts each query result and
// compares it with the output beats in order.
// ----------------------------------------------------------------------------
module grid_disc_occupancy_check_checker
    import gdoc_pkg::*;
#(
    parameter int MAP_SIDE         = 256,
    parameter int MAX_RADIUS_CELLS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        opcode,
    input  logic [15:0] cell_index,
    input  logic [7:0]  cell_value,
    input  logic [31:0] point_x,
    input  logic [31:0] point_y,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        occupied,
    input  logic        in_map,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          pending,
    output int          failures
);

    typedef struct packed {
        logic occupied;
        logic in_map;
    } verdict_t;

    verdict_t        verdicts[$];
    logic signed [7:0] cells[MAP_SIDE*MAP_SIDE];

    longint          grid_w;
    longint          grid_h;
    longint          org_x;
    longint          org_y;
    longint          yaw_cos;
    longint          yaw_sin;
    longint          cell_sz;
    longint          radius;

    // Division that rounds toward minus infinity.
    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic logic is_obstacle(longint idx);
        return cells[idx] >= OBSTACLE_LEVEL;
    endfunction

    function automatic verdict_t disc_verdict(logic [31:0] px, logic [31:0] py);
        longint w, h, cs, dx, dy, gx, gy, dv, cx, cy, ri, mx, my;
        longint unsigned r, rsq, wx, wy, ax, ay;
        verdict_t v;
        v = '0;
        w = (grid_w > MAP_SIDE) ? MAP_SIDE : grid_w;
        h = (grid_h > MAP_SIDE) ? MAP_SIDE : grid_h;
        cs = (cell_sz == 0) ? 1 : cell_sz;
        dx = longint'($signed(px)) - org_x;
        dy = longint'($signed(py)) - org_y;
        gx = yaw_cos * dx + yaw_sin * dy;
        gy = yaw_cos * dy - yaw_sin * dx;
        dv = cs << 14;
        cx = floor_div(gx, dv);
        cy = floor_div(gy, dv);
        if (cx < 0 || cy < 0 || cx >= w || cy >= h)
            return v;
        v.in_map = 1'b1;
        if (radius == 0)
        begin
            v.occupied = is_obstacle(cy * w + cx);
            return v;
        end
        r = (radius + cs - 1) / cs;
        if (r < 1)
            r = 1;
        if (r > MAX_RADIUS_CELLS)
            r = MAX_RADIUS_CELLS;
        ri = longint'(r);
        rsq = radius * radius;
        // Squares of far offsets may wrap in 64 bits; the unsigned compare
        // below keeps exactly that behavior.
        for (longint oy = -ri; oy <= ri; oy++)
        begin
            for (longint ox = -ri; ox <= ri; ox++)
            begin
                mx = cx + ox;
                my = cy + oy;
                if (mx < 0 || my < 0 || mx >= w || my >= h)
                    continue;
                wx = longint'(ox < 0 ? -ox : ox) * cs;
                wy = longint'(oy < 0 ? -oy : oy) * cs;
                ax = wx * wx;
                ay = wy * wy;
                if (ax > rsq || ay > rsq || ax + ay > rsq)
                    continue;
                if (is_obstacle(my * w + mx))
                begin
                    v.occupied = 1'b1;
                    return v;
                end
            end
        end
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            grid_w   <= 256;
            grid_h   <= 256;
            org_x    <= 0;
            org_y    <= 0;
            yaw_cos  <= 16384;
            yaw_sin  <= 0;
            cell_sz  <= 6554;
            radius   <= 6554;
            failures <= 0;
            pending  <= 0;
            verdicts.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_GRID_WIDTH:   grid_w  <= cfg_data[8:0];
                    REG_GRID_HEIGHT:  grid_h  <= cfg_data[8:0];
                    REG_ORIGIN_X:     org_x   <= longint'($signed(cfg_data));
                    REG_ORIGIN_Y:     org_y   <= longint'($signed(cfg_data));
                    REG_ORIGIN_COS:   yaw_cos <= longint'($signed(cfg_data[15:0]));
                    REG_ORIGIN_SIN:   yaw_sin <= longint'($signed(cfg_data[15:0]));
                    REG_CELL_SIZE:    cell_sz <= cfg_data[30:0];
                    REG_CLEAR_RADIUS: radius  <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                if (opcode == OP_WRITE)
                    cells[cell_index] = cell_value;
                else
                    verdicts.insert(verdicts.size(), disc_verdict(point_x, point_y));
            end
            if (out_valid && !out_stall)
            begin
                if (verdicts.size() == 0)
                begin
                    $display("%0t: unexpected result beat occupied=%0b in_map=%0b",
                             $time, occupied, in_map);
                    failures <= failures + 1;
                end
                else
                begin
                    want = verdicts.pop_front();
                    if (want.occupied !== occupied || want.in_map !== in_map)
                    begin
                        $display("%0t: mismatch expected occ=%0b map=%0b, got occ=%0b map=%0b",
                                 $time, want.occupied, want.in_map, occupied, in_map);
                        failures <= failures + 1;
                    end
                end
            end
            pending <= verdicts.size();
        end
    end

endmodule

/* test/grid_disc_occupancy_check_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_disc_occupancy_check_test: testbench of the grid disc occupancy check
// Fills the first cells of the memory, then runs a series of register settings
// whose grids stay inside those cells, with directed and random cell writes
// and queries, under random input gaps and output stalls. A checker beside
// the block predicts and compares results.
// ----------------------------------------------------------------------------
module grid_disc_occupancy_check_test;
    import gdoc_pkg::*;

    localparam int PHASES      = 7;
    localparam int RAND_ITEMS  = 32;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        opcode;
    logic [15:0] cell_index;
    logic [7:0]  cell_value;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic        out_valid;
    logic        out_stall;
    logic        occupied;
    logic        in_map;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    int          pending;
    int          failures;

    // Idle percentages of the sender and the receiver, changed as items go.
    int          send_idle;
    int          recv_idle;
    int          beats_sent;

    // Register settings per phase. Every grid covers at most the 256 cells
    // written up front; phase 0 keeps the other reset values and the rest
    // sweep the extremes of every register.
    longint set_w[PHASES]   = '{16, 16, 16, 511, 0, 1, 1};
    longint set_h[PHASES]   = '{16, 16, 12, 1, 7, 1, 300};
    longint set_ox[PHASES]  = '{0, 0, -196608, -2147483648, 65536, 12345, 2147483647};
    longint set_oy[PHASES]  = '{0, 0, 131072, 1000000, -65536, -999, -2147483648};
    longint set_cos[PHASES] = '{16384, 16384, 0, -16384, 16384, 11585, -16384};
    longint set_sin[PHASES] = '{0, 0, 16384, 0, 0, 11585, 16384};
    longint set_cs[PHASES]  = '{6554, 6554, 65536, 1048576, 65536, 0, 2147483647};
    longint set_rad[PHASES] = '{6554, 0, 196608, 2147483647, 65536, 1, 1};

    grid_disc_occupancy_check u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .cell_index (cell_index),
        .cell_value (cell_value),
        .point_x    (point_x),
        .point_y    (point_y),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .occupied   (occupied),
        .in_map     (in_map),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    grid_disc_occupancy_check_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .cell_index (cell_index),
        .cell_value (cell_value),
        .point_x    (point_x),
        .point_y    (point_y),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .occupied   (occupied),
        .in_map     (in_map),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .failures   (failures)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // The receiver stalls at random, one decision per cycle.
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle);

    // Presents one input beat and holds it until the block takes it. Gaps go
    // in before the beat so that valid only drops when the sender idles.
    task automatic send_beat(logic op, logic [15:0] idx, logic [7:0] val,
                             logic [31:0] px, logic [31:0] py);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        cell_index <= idx;
        cell_value <= val;
        point_x    <= px;
        point_y    <= py;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_sent++;
        // Three idling regimes: slow receiver, then slow sender, then none.
        if (beats_sent < 167)
        begin
            send_idle = 31;
            recv_idle = 85;
        end
        else if (beats_sent < 333)
        begin
            send_idle = 85;
            recv_idle = 31;
        end
        else
        begin
            send_idle = 0;
            recv_idle = 0;
        end
    endtask

    task automatic write_reg(cfg_reg_t idx, longint d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d[31:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Registers change only with nothing in flight. Writes give no result,
    // so a further wait covers a write still settling in the memory.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Cell values lean toward free and unknown so that discs are not always
    // hit; about one in eight is an obstacle.
    function automatic logic [7:0] cell_level();
        case ($urandom_range(0, 7))
            0:       return 8'($urandom_range(99, 127));
            1:       return 8'hFF;
            2:       return 8'($urandom);
            default: return 8'($urandom_range(0, 98));
        endcase
    endfunction

    // Picks a grid coordinate near the used area, turns it back through the
    // yaw and adds the origin, so most queries land in or just beside the map.
    task automatic aimed_query(int ph);
        longint cs, gx, gy, dx, dy, wx, hy;
        cs = (set_cs[ph] == 0) ? 1 : set_cs[ph];
        wx = (set_w[ph] > 256) ? 256 : set_w[ph];
        hy = (set_h[ph] > 256) ? 256 : set_h[ph];
        gx = ($urandom_range(0, 31) == 0) ? -1 : longint'($urandom_range(0, wx));
        gy = ($urandom_range(0, 31) == 0) ? -1 : longint'($urandom_range(0, hy));
        gx = gx * cs + longint'($urandom_range(0, 65535)) % cs;
        gy = gy * cs + longint'($urandom_range(0, 65535)) % cs;
        dx = (set_cos[ph] * gx - set_sin[ph] * gy) / 16384;
        dy = (set_sin[ph] * gx + set_cos[ph] * gy) / 16384;
        send_beat(OP_QUERY, 16'($urandom), 8'($urandom),
                  32'(set_ox[ph] + dx), 32'(set_oy[ph] + dy));
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        opcode     = OP_WRITE;
        cell_index = '0;
        cell_value = '0;
        point_x    = '0;
        point_y    = '0;
        out_stall  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_GRID_WIDTH;
        cfg_data   = '0;
        send_idle  = 31;
        recv_idle  = 85;
        beats_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first 256 cells are written up front; every phase grid stays
        // inside them, so no phase query reads an unwritten location.
        for (int i = 0; i < 256; i++)
            send_beat(OP_WRITE, 16'(i), cell_level(), 32'($urandom), 32'($urandom));

        // Directed part at the reset settings. Queries near the origin and
        // near the far corner find every cell of their disc written just before them.
        send_beat(OP_WRITE, 16'd256, 8'd0, '0, '0);
        send_beat(OP_WRITE, 16'd1, 8'd0, '0, '0);
        send_beat(OP_WRITE, 16'd0, 8'd99, '0, '0);
        send_beat(OP_QUERY, '0, '0, 32'd0, 32'd0);
        send_beat(OP_WRITE, 16'd0, 8'd98, '1, '1);
        send_beat(OP_QUERY, '1, '1, 32'd0, 32'd0);
        send_beat(OP_WRITE, 16'd257, 8'd127, '0, '0);
        send_beat(OP_QUERY, '0, '0, 32'd6553, 32'd6553);
        send_beat(OP_QUERY, '0, '0, 32'hFFFF_FFFF, 32'd0);
        send_beat(OP_QUERY, '0, '0, 32'd0, 32'hFFFF_FFFF);
        send_beat(OP_QUERY, '0, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_beat(OP_QUERY, '0, '0, 32'h8000_0000, 32'h8000_0000);
        send_beat(OP_WRITE, 16'd65534, 8'd0, '0, '0);
        send_beat(OP_WRITE, 16'd65279, 8'd0, '0, '0);
        send_beat(OP_WRITE, 16'd65535, 8'd99, '0, '0);
        send_beat(OP_QUERY, '0, '0, 32'd1677720, 32'd1677720);
        send_beat(OP_QUERY, '0, '0, 32'd1677823, 32'd1677823);
        send_beat(OP_QUERY, '0, '0, 32'd1677824, 32'd1677824);
        send_beat(OP_WRITE, 16'd65535, 8'hFF, '0, '0);
        send_beat(OP_QUERY, '0, '0, 32'd1677800, 32'd1677800);
        send_beat(OP_WRITE, 16'd65535, 8'h80, '0, '0);
        send_beat(OP_QUERY, '0, '0, 32'd1677800, 32'd1677800);
        send_beat(OP_WRITE, 16'hAAAA, 8'h55, '0, '0);
        send_beat(OP_WRITE, 16'h5555, 8'hAA, '0, '0);

        // Each phase programs all registers, then mixes random writes with
        // aimed and fully random queries.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            write_reg(REG_GRID_WIDTH,   set_w[ph]);
            write_reg(REG_GRID_HEIGHT,  set_h[ph]);
            write_reg(REG_ORIGIN_X,     set_ox[ph]);
            write_reg(REG_ORIGIN_Y,     set_oy[ph]);
            write_reg(REG_ORIGIN_COS,   set_cos[ph]);
            write_reg(REG_ORIGIN_SIN,   set_sin[ph]);
            write_reg(REG_CELL_SIZE,    set_cs[ph]);
            write_reg(REG_CLEAR_RADIUS, set_rad[ph]);
            for (int n = 0; n < RAND_ITEMS; n++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2:
                        send_beat(OP_WRITE, 16'($urandom), cell_level(),
                                  32'($urandom), 32'($urandom));
                    3:
                        send_beat(OP_QUERY, 16'($urandom), 8'($urandom),
                                  32'($urandom), 32'($urandom));
                    default:
                        aimed_query(ph);
                endcase
            end
        end

        drain();
        repeat (500) @(posedge clk);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // About 500 beats, stretched by stalls, stay well inside this
    // bound.
    initial
    begin
        #40ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
src/gdoc_pkg.sv
src/gdoc_divider.sv
src/gdoc_cell_mem.sv
src/grid_disc_occupancy_check.sv
test/grid_disc_occupancy_check_checker.sv
test/grid_disc_occupancy_check_test.sv
